/* rtl/bmtb_pkg.sv */
// Shared constants, types and the 5x5 uppercase glyph table for the text blitter.
// No dependencies; imported by every module of the block.
package bmtb_pkg;

	localparam int PAGE_SIZE_DEF = 60;

	// Signed coordinate widths, wide enough for every start column and glyph offset
	localparam int ROW_W = 8;
	localparam int COL_W = 12;

	localparam logic OP_PLACE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic FONT_SMALL = 1'b0;
	localparam logic FONT_BIG   = 1'b1;

	localparam logic [1:0] ALIGN_COL    = 2'd0;
	localparam logic [1:0] ALIGN_LEFT   = 2'd1;
	localparam logic [1:0] ALIGN_RIGHT  = 2'd2;
	localparam logic [1:0] ALIGN_CENTRE = 2'd3;

	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_A     = 8'd65;
	localparam logic [7:0] CH_Z     = 8'd90;

	localparam logic [2:0] GLYPH_LAST = 3'd4;

	typedef struct packed {
		logic signed [ROW_W-1:0] r;
		logic signed [COL_W-1:0] c;
	} coord_t;

	// One glyph per entry, top row in the high five bits, bit 4 of a row = leftmost pixel
	localparam logic [24:0] GLYPH_ROM [26] = '{
		{5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
		{5'h0F, 5'h11, 5'h10, 5'h10, 5'h0F}, {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
		{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
		{5'h0F, 5'h10, 5'h13, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
		{5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, {5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
		{5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
		{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, {5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
		{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
		{5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F}, {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
		{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, {5'h1F, 5'h15, 5'h04, 5'h04, 5'h0E},
		{5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
		{5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
		{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F}
	};

	// Pixel k of glyph row j; indexes past 'Z' or past the last row give a blank
	function automatic logic glyph_pixel(input logic [4:0] idx, input logic [2:0] j,
		input logic [2:0] k);
		logic [24:0] g;
		logic        bit_v;
		g     = '0;
		bit_v = 1'b0;
		if (idx < 5'd26 && j <= GLYPH_LAST && k <= GLYPH_LAST) begin
			g     = GLYPH_ROM[idx];
			bit_v = g[5'd24 - 5'(j) * 5'd5 - 5'(k)];
		end
		return bit_v;
	endfunction

endpackage

/* rtl/bmtb_addr_unit.sv */
// Shared clip-and-address unit: checks a signed row/column against the page and
// forms the flat cell address, registered. Depends on bmtb_pkg.
module bmtb_addr_unit
	import bmtb_pkg::*;
#(
	parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   load,
	input  coord_t                                 crd,
	output logic                                   ok,
	output logic [$clog2(PAGE_SIZE*PAGE_SIZE)-1:0] addr
);

	localparam int ADDR_W = $clog2(PAGE_SIZE*PAGE_SIZE);
	localparam int IDX_W  = $clog2(PAGE_SIZE);
	localparam logic signed [ROW_W-1:0] P_R = ROW_W'(PAGE_SIZE);
	localparam logic signed [COL_W-1:0] P_C = COL_W'(PAGE_SIZE);

	logic signed [ROW_W-1:0] r;
	logic signed [COL_W-1:0] c;
	logic                    ok_d;
	logic [ADDR_W-1:0]       rr;
	logic [ADDR_W-1:0]       cc;
	logic [ADDR_W-1:0]       addr_d;
	logic                    ok_q;
	logic [ADDR_W-1:0]       addr_q;

	assign r      = crd.r;
	assign c      = crd.c;
	assign ok_d   = (r >= 0) && (r < P_R) && (c >= 0) && (c < P_C);
	assign rr     = ADDR_W'(r[IDX_W-1:0]);
	assign cc     = ADDR_W'(c[IDX_W-1:0]);
	assign addr_d = rr * ADDR_W'(PAGE_SIZE) + cc;

	// hold the last computed address until the next load
	always_ff @(posedge clk) begin
		if (load) begin
			ok_q   <= ok_d;
			addr_q <= addr_d;
		end
	end

	assign ok   = ok_q;
	assign addr = addr_q;

endmodule

/* rtl/bmtb_page_mem.sv */
// Single-port page memory, one byte per cell, registered read data.
// Depends on bmtb_pkg.
module bmtb_page_mem
	import bmtb_pkg::*;
#(
	parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [$clog2(PAGE_SIZE*PAGE_SIZE)-1:0] addr,
	input  logic [7:0]                             wdata,
	output logic [7:0]                             rdata
);

	localparam int DEPTH = PAGE_SIZE * PAGE_SIZE;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bitmap_text_blitter.sv */
// Top level of the bitmap text blitter: sequencer, clearing pass and output register.
// Depends on bmtb_pkg, bmtb_addr_unit and bmtb_page_mem.
//
// The block keeps a PAGE_SIZE x PAGE_SIZE page of byte cells. A request is taken at a rising
// edge with start high and busy low. After reset the block sweeps the page to '.' one cell a
// cycle, with busy high. A read request passes through S_ADDR, S_RD and S_RES, returns the
// cell in one valid pulse on cell_value and leaves '.' in the cell; busy drops for the cycle
// that carries the pulse, and the receiver cannot stall it, so sample cell_value whenever
// valid is high. A place request gives no result: S_START and S_X form the start column, then
// a small-font character is written from S_SMALL, a big-font letter sends its 25 pixels
// through the shared clip-and-address unit in S_GLYPH, one pixel a cycle, and a big-font
// non-letter writes nothing. The single memory port and the shared address unit handle one
// cell at a time.
module bitmap_text_blitter
	import bmtb_pkg::*;
#(
	parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       opcode,
	input  logic       font,
	input  logic [1:0] align,
	input  logic [5:0] row,
	input  logic [5:0] column,
	input  logic [7:0] text_length,
	input  logic [7:0] char_pos,
	input  logic [7:0] char_code,
	output logic       valid,
	output logic [7:0] cell_value
);

	localparam int ADDR_W = $clog2(PAGE_SIZE*PAGE_SIZE);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(PAGE_SIZE*PAGE_SIZE - 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_START = 4'd2;
	localparam logic [3:0] S_X     = 4'd3;
	localparam logic [3:0] S_SMALL = 4'd4;
	localparam logic [3:0] S_GLYPH = 4'd5;
	localparam logic [3:0] S_ADDR  = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_RES   = 4'd8;

	logic [3:0]              state_q;
	logic [ADDR_W-1:0]       clr_cnt_q;

	// request fields, held for the whole item
	logic                    font_q;
	logic [1:0]              align_q;
	logic [5:0]              row_q;
	logic [5:0]              col_q;
	logic [7:0]              len_q;
	logic [7:0]              pos_q;
	logic [7:0]              code_q;

	logic signed [COL_W-1:0] start_q;
	logic signed [COL_W-1:0] x_q;
	logic [2:0]              j_q;
	logic [2:0]              k_q;

	logic                    wr_pend_s1;
	logic [7:0]              wdata_s1;
	logic                    valid_q;
	logic [7:0]              cell_value_q;

	logic signed [ROW_W-1:0] row_m1;
	logic signed [COL_W-1:0] col_m1;
	logic signed [COL_W-1:0] len_ext;
	logic signed [COL_W-1:0] len_l;
	logic signed [COL_W-1:0] pos_ext;
	logic signed [COL_W-1:0] pos_l;
	logic signed [COL_W-1:0] start_d;
	logic                    is_letter;
	logic [4:0]              glyph_idx;

	logic                    au_load;
	coord_t                  au_crd;
	logic                    au_ok;
	logic [ADDR_W-1:0]       au_addr;
	logic                    feed_wr;
	logic [7:0]              feed_data;

	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_addr;
	logic [7:0]              mem_wdata;
	logic [7:0]              mem_rdata;

	// one-based fields to zero-based signed coordinates
	assign row_m1 = ROW_W'(row_q) - ROW_W'(1);
	assign col_m1 = COL_W'(col_q) - COL_W'(1);

	// string width in cells: six columns a letter for the big font
	assign len_ext = COL_W'(len_q);
	assign len_l   = (font_q == FONT_BIG) ? (len_ext <<< 2) + (len_ext <<< 1) : len_ext;
	assign pos_ext = COL_W'(pos_q);
	assign pos_l   = (font_q == FONT_BIG) ? (pos_ext <<< 2) + (pos_ext <<< 1) : pos_ext;

	always_comb begin
		unique case (align_q)
			ALIGN_COL:    start_d = col_m1;
			ALIGN_LEFT:   start_d = '0;
			ALIGN_RIGHT:  start_d = COL_W'(PAGE_SIZE) - len_l;
			ALIGN_CENTRE: start_d = COL_W'(PAGE_SIZE / 2) - (len_l >>> 1);
			default:      start_d = '0;
		endcase
	end

	assign is_letter = (code_q >= CH_A) && (code_q <= CH_Z);
	assign glyph_idx = 5'(code_q - CH_A);

	// feed the shared address unit: read cell, small character or the current glyph pixel
	always_comb begin
		au_load   = 1'b0;
		au_crd.r  = row_m1;
		au_crd.c  = col_m1;
		feed_wr   = 1'b0;
		feed_data = code_q;
		unique case (state_q)
			S_ADDR: begin
				au_load = 1'b1;
			end
			S_SMALL: begin
				au_load  = 1'b1;
				au_crd.c = x_q;
				feed_wr  = (code_q != CH_SPACE);
			end
			S_GLYPH: begin
				au_load   = 1'b1;
				au_crd.r  = row_m1 + ROW_W'(j_q);
				au_crd.c  = x_q + COL_W'(k_q);
				feed_wr   = glyph_pixel(glyph_idx, j_q, k_q);
				feed_data = CH_STAR;
			end
			default: begin
				au_load = 1'b0;
			end
		endcase
	end

	bmtb_addr_unit #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_addr (
		.clk (clk),
		.load(au_load),
		.crd (au_crd),
		.ok  (au_ok),
		.addr(au_addr)
	);

	// memory port: clearing sweep, then pending character or pixel write, then the clear-after-read
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = au_addr;
		mem_wdata = CH_DOT;
		if (state_q == S_CLEAR) begin
			mem_we   = 1'b1;
			mem_addr = clr_cnt_q;
		end else if (wr_pend_s1) begin
			mem_we    = au_ok;
			mem_wdata = wdata_s1;
		end else if (state_q == S_RES) begin
			mem_we = au_ok;
		end
	end

	bmtb_page_mem #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			wr_pend_s1 <= 1'b0;
			valid_q    <= 1'b0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			// a write issued this cycle lands in the next cycle, after the address is registered
			wr_pend_s1 <= feed_wr;
			valid_q    <= (state_q == S_RES);
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= (opcode == OP_READ) ? S_ADDR : S_START;
					end
				end
				S_START: begin
					state_q <= S_X;
				end
				S_X: begin
					j_q <= '0;
					k_q <= '0;
					if (font_q == FONT_SMALL) begin
						state_q <= S_SMALL;
					end else if (is_letter) begin
						state_q <= S_GLYPH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SMALL: begin
					state_q <= S_IDLE;
				end
				S_GLYPH: begin
					// advance column, then row; drop out after the last pixel
					if (k_q == GLYPH_LAST) begin
						k_q <= '0;
						j_q <= j_q + 3'd1;
						if (j_q == GLYPH_LAST) begin
							state_q <= S_IDLE;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_ADDR: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_RES;
				end
				S_RES: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			font_q  <= font;
			align_q <= align;
			row_q   <= row;
			col_q   <= column;
			len_q   <= text_length;
			pos_q   <= char_pos;
			code_q  <= char_code;
		end
		if (state_q == S_START) begin
			start_q <= start_d;
		end
		if (state_q == S_X) begin
			x_q <= start_q + pos_l;
		end
		wdata_s1 <= feed_data;
		if (state_q == S_RES) begin
			// a cell off the page reads as '.'
			cell_value_q <= au_ok ? mem_rdata : CH_DOT;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign valid      = valid_q;
	assign cell_value = cell_value_q;

endmodule
